>>> hw/rtl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants for the ASCII frame receiver: character codes,
// frame positions, event codes and the classified-character record.
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_8 = 8'h38;
  localparam logic [7:0] CH_0 = 8'h30;

  localparam logic [7:0] ADDR_HI_RESET = 8'd48;
  localparam logic [7:0] ADDR_LO_RESET = 8'd49;

  // Configuration register indexes
  localparam logic CFG_ADDR_HI = 1'b0;
  localparam logic CFG_ADDR_LO = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    POS_HUNT    = 4'd0,
    POS_F2      = 4'd1,
    POS_ADDR_HI = 4'd2,
    POS_ADDR_LO = 4'd3,
    POS_SKIP_A  = 4'd4,
    POS_SKIP_B  = 4'd5,
    POS_LEN_HI  = 4'd6,
    POS_LEN_LO  = 4'd7,
    POS_PAYLOAD = 4'd8,
    POS_TRAIL_A = 4'd9,
    POS_TRAIL_B = 4'd10
  } frame_pos_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ERROR = 2'd2
  } frame_event_t;

  // One received character with its classification
  typedef struct packed {
    logic [7:0] ch;
    logic       is_f;
    logic       is_8;
    logic       is_0;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       addr_hi_hit;
    logic       addr_lo_hit;
  } char_class_t;

endpackage

>>> hw/rtl/ascii_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// ascii_frame_receiver_top
// Character-by-character frame receiver: 'F','F', station address, two
// ignored characters, two hex length digits, payload, trailer '8','0'.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_char) takes one received
//   character per item. Output channel (out_valid / out_stall) returns
//   exactly one result item per character: payload_valid and payload_char
//   for payload characters, frame_event 1 on a good trailer, 2 on any
//   header, address, length or trailer error (the block then hunts again).
//   Configuration: cfg_we with cfg_index 0 writes the first address
//   character, cfg_index 1 the second; write only while the block is idle.
//   A result passes through the queue and the output register before it is
//   presented on out_valid. Throughput: one character per cycle while the
//   receiver does not hold out_stall.
//   A front end classifies characters into a two-entry queue, so input and
//   output stall independently; in_stall rises only when that queue is full
//   because the receiver holds out_stall. A stalled result holds steady.
//   Reset (rst, synchronous): address reverts to '0','1', the queue and the
//   output empty, and the receiver starts in header hunt.
// ----------------------------------------------------------------------------
module ascii_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       payload_valid,
  output logic [7:0] payload_char,
  output logic [1:0] frame_event
);

  // front to queue
  logic                 push;
  afr_pkg::char_class_t push_data;
  logic                 q_full;

  // queue to back
  logic                 q_valid;
  logic                 pop;
  afr_pkg::char_class_t head;

  // classify characters and hold the address registers
  afr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_char   (rx_char),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decouple the two sides
  afr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head)
  );

  // run the frame state machine and register the result
  afr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_valid (payload_valid),
    .payload_char  (payload_char),
    .frame_event   (frame_event)
  );

endmodule

>>> hw/rtl/afr_front.sv
// ----------------------------------------------------------------------------
// afr_front
// Input side: holds the station address registers, classifies each accepted
// character and pushes the record into the queue.
// ----------------------------------------------------------------------------
module afr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_char,
  input  logic                 q_full,
  output logic                 push,
  output afr_pkg::char_class_t push_data
);

  logic [7:0] addr_hi;
  logic [7:0] addr_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_hi <= afr_pkg::ADDR_HI_RESET;
      addr_lo <= afr_pkg::ADDR_LO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        afr_pkg::CFG_ADDR_HI: addr_hi <= cfg_data;
        afr_pkg::CFG_ADDR_LO: addr_lo <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data             = '0;
    push_data.ch          = rx_char;
    push_data.is_f        = (rx_char == afr_pkg::CH_F);
    push_data.is_8        = (rx_char == afr_pkg::CH_8);
    push_data.is_0        = (rx_char == afr_pkg::CH_0);
    push_data.addr_hi_hit = (rx_char == addr_hi);
    push_data.addr_lo_hit = (rx_char == addr_lo);
    // decode hex digit: 0-9, A-F, a-f
    if (rx_char >= 8'h30 && rx_char <= 8'h39) begin
      push_data.hex_ok  = 1'b1;
      push_data.hex_val = rx_char[3:0];
    end else if ((rx_char >= 8'h41 && rx_char <= 8'h46) ||
                 (rx_char >= 8'h61 && rx_char <= 8'h66)) begin
      push_data.hex_ok  = 1'b1;
      push_data.hex_val = rx_char[3:0] + 4'd9;
    end
  end

endmodule

>>> hw/rtl/afr_queue.sv
// ----------------------------------------------------------------------------
// afr_queue
// Short FIFO of classified characters between the front and the back.
// ----------------------------------------------------------------------------
module afr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  afr_pkg::char_class_t push_data,
  input  logic                 pop,
  output logic                 q_valid,
  output logic                 q_full,
  output afr_pkg::char_class_t head
);

  afr_pkg::char_class_t entries [afr_pkg::QUEUE_DEPTH];

  logic [afr_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [afr_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [afr_pkg::QUEUE_CNT_W-1:0] count;

  assign q_valid = (count != '0);
  assign q_full  = (count == afr_pkg::QUEUE_CNT_W'(afr_pkg::QUEUE_DEPTH));
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == afr_pkg::QUEUE_PTR_W'(afr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == afr_pkg::QUEUE_PTR_W'(afr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/afr_back.sv
// ----------------------------------------------------------------------------
// afr_back
// Frame state machine: consumes classified characters from the queue,
// tracks the payload count and drives the registered result.
// ----------------------------------------------------------------------------
module afr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  afr_pkg::char_class_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 payload_valid,
  output logic [7:0]           payload_char,
  output logic [1:0]           frame_event
);

  afr_pkg::frame_pos_t pos;
  afr_pkg::frame_pos_t pos_next;
  logic [8:0]          target;
  logic [8:0]          target_next;
  logic [8:0]          seen;
  logic [8:0]          seen_next;
  logic [8:0]          len_word;
  logic [8:0]          seen_inc;

  logic                    res_pvalid;
  logic [7:0]              res_pchar;
  afr_pkg::frame_event_t   res_event;

  // advance when the output register is free or being emptied
  assign pop = q_valid && (!out_valid || !out_stall);

  assign len_word = {target[7:0] | {4'd0, head.hex_val}, 1'b0};
  assign seen_inc = seen + 9'd1;

  // next state
  always_comb begin
    pos_next    = pos;
    target_next = target;
    seen_next   = seen;
    case (pos)
      afr_pkg::POS_F2:
        pos_next = head.is_f ? afr_pkg::POS_ADDR_HI : afr_pkg::POS_HUNT;
      afr_pkg::POS_ADDR_HI:
        pos_next = head.addr_hi_hit ? afr_pkg::POS_ADDR_LO : afr_pkg::POS_HUNT;
      afr_pkg::POS_ADDR_LO:
        pos_next = head.addr_lo_hit ? afr_pkg::POS_SKIP_A : afr_pkg::POS_HUNT;
      afr_pkg::POS_SKIP_A:
        pos_next = afr_pkg::POS_SKIP_B;
      afr_pkg::POS_SKIP_B:
        pos_next = afr_pkg::POS_LEN_HI;
      afr_pkg::POS_LEN_HI: begin
        if (head.hex_ok) begin
          pos_next    = afr_pkg::POS_LEN_LO;
          target_next = {1'b0, head.hex_val, 4'd0};
        end else begin
          pos_next = afr_pkg::POS_HUNT;
        end
      end
      afr_pkg::POS_LEN_LO: begin
        if (head.hex_ok) begin
          target_next = len_word;
          seen_next   = '0;
          pos_next    = (len_word == '0) ? afr_pkg::POS_TRAIL_A : afr_pkg::POS_PAYLOAD;
        end else begin
          pos_next = afr_pkg::POS_HUNT;
        end
      end
      afr_pkg::POS_PAYLOAD: begin
        seen_next = seen_inc;
        if (seen_inc >= target) begin
          pos_next = afr_pkg::POS_TRAIL_A;
        end
      end
      afr_pkg::POS_TRAIL_A:
        pos_next = head.is_8 ? afr_pkg::POS_TRAIL_B : afr_pkg::POS_HUNT;
      afr_pkg::POS_TRAIL_B:
        pos_next = afr_pkg::POS_HUNT;
      default: begin
        // header hunt
        target_next = '0;
        seen_next   = '0;
        pos_next    = head.is_f ? afr_pkg::POS_F2 : afr_pkg::POS_HUNT;
      end
    endcase
    // any return to hunt drops the frame counters
    if (pos_next == afr_pkg::POS_HUNT) begin
      target_next = '0;
      seen_next   = '0;
    end
  end

  // result of this character
  always_comb begin
    res_pvalid = 1'b0;
    res_pchar  = '0;
    res_event  = afr_pkg::EV_NONE;
    case (pos)
      afr_pkg::POS_F2:
        if (!head.is_f) res_event = afr_pkg::EV_ERROR;
      afr_pkg::POS_ADDR_HI:
        if (!head.addr_hi_hit) res_event = afr_pkg::EV_ERROR;
      afr_pkg::POS_ADDR_LO:
        if (!head.addr_lo_hit) res_event = afr_pkg::EV_ERROR;
      afr_pkg::POS_SKIP_A, afr_pkg::POS_SKIP_B: ;
      afr_pkg::POS_LEN_HI, afr_pkg::POS_LEN_LO:
        if (!head.hex_ok) res_event = afr_pkg::EV_ERROR;
      afr_pkg::POS_PAYLOAD: begin
        res_pvalid = 1'b1;
        res_pchar  = head.ch;
      end
      afr_pkg::POS_TRAIL_A:
        if (!head.is_8) res_event = afr_pkg::EV_ERROR;
      afr_pkg::POS_TRAIL_B:
        res_event = head.is_0 ? afr_pkg::EV_DONE : afr_pkg::EV_ERROR;
      default:
        if (!head.is_f) res_event = afr_pkg::EV_ERROR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= afr_pkg::POS_HUNT;
      target    <= '0;
      seen      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        pos    <= pos_next;
        target <= target_next;
        seen   <= seen_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      payload_valid <= res_pvalid;
      payload_char  <= res_pchar;
      frame_event   <= res_event;
    end
  end

endmodule

>>> test/afr_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afr_frame_checker
// Watches both channels and the register port of the ASCII frame receiver,
// keeps its own copy of the frame state, and checks every result item field
// by field against the outcome predicted for its character.
// ----------------------------------------------------------------------------
module afr_frame_checker
  import afr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_char,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       payload_valid,
  input  logic [7:0] payload_char,
  input  logic [1:0] frame_event,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic         pay_valid;
    logic [7:0]   pay_char;
    frame_event_t event_code;
  } char_outcome_t;

  char_outcome_t outcomes_due[$];

  logic [7:0] addr_hi;
  logic [7:0] addr_lo;
  frame_pos_t pos;
  logic [8:0] len_target;
  logic [8:0] len_seen;

  // 0..15 for a hex digit, 16 for anything else
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b0, c[3:0] + 4'd9};
    return 5'd16;
  endfunction

  function automatic void drop_frame();
    pos        = POS_HUNT;
    len_target = '0;
    len_seen   = '0;
  endfunction

  // Advance the frame state by one character and return what it produces
  function automatic char_outcome_t decode_char(input logic [7:0] c);
    char_outcome_t res;
    logic [4:0]    nib;
    logic          bad;
    res = '{pay_valid: 1'b0, pay_char: 8'h00, event_code: EV_NONE};
    bad = 1'b0;
    case (pos)
      POS_F2:      if (c != CH_F) bad = 1'b1; else pos = POS_ADDR_HI;
      POS_ADDR_HI: if (c != addr_hi) bad = 1'b1; else pos = POS_ADDR_LO;
      POS_ADDR_LO: if (c != addr_lo) bad = 1'b1; else pos = POS_SKIP_A;
      POS_SKIP_A:  pos = POS_SKIP_B;
      POS_SKIP_B:  pos = POS_LEN_HI;
      POS_LEN_HI: begin
        nib = hex_nibble(c);
        if (nib[4]) begin
          bad = 1'b1;
        end else begin
          len_target = {1'b0, nib[3:0], 4'b0000};
          pos        = POS_LEN_LO;
        end
      end
      POS_LEN_LO: begin
        nib = hex_nibble(c);
        if (nib[4]) begin
          bad = 1'b1;
        end else begin
          len_target = {len_target[7:4], nib[3:0], 1'b0};
          len_seen   = '0;
          if (len_target == '0) pos = POS_TRAIL_A;
          else pos = POS_PAYLOAD;
        end
      end
      POS_PAYLOAD: begin
        res.pay_valid = 1'b1;
        res.pay_char  = c;
        len_seen      = len_seen + 9'd1;
        if (len_seen >= len_target) pos = POS_TRAIL_A;
      end
      POS_TRAIL_A: if (c != CH_8) bad = 1'b1; else pos = POS_TRAIL_B;
      POS_TRAIL_B: begin
        if (c != CH_0) begin
          bad = 1'b1;
        end else begin
          res.event_code = EV_DONE;
          drop_frame();
        end
      end
      default: begin
        if (c != CH_F) begin
          bad = 1'b1;
        end else begin
          len_target = '0;
          len_seen   = '0;
          pos        = POS_F2;
        end
      end
    endcase
    if (bad) begin
      res.event_code = EV_ERROR;
      drop_frame();
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    char_outcome_t want;
    if (rst) begin
      addr_hi = ADDR_HI_RESET;
      addr_lo = ADDR_LO_RESET;
      drop_frame();
      outcomes_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ADDR_HI) addr_hi = cfg_data;
        else addr_lo = cfg_data;
      end
      // results leave before the item that is accepted on the same edge
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          errors++;
          $display("%0t: result expected none actual pv=%0b ch=%02h ev=%0d", $time,
                   payload_valid, payload_char, frame_event);
        end else begin
          want = outcomes_due.pop_front();
          if (payload_valid !== want.pay_valid || payload_char !== want.pay_char ||
              frame_event !== want.event_code) begin
            errors++;
            if (payload_valid !== want.pay_valid)
              $display("%0t: payload_valid expected %0b actual %0b", $time,
                       want.pay_valid, payload_valid);
            if (payload_char !== want.pay_char)
              $display("%0t: payload_char expected %02h actual %02h", $time,
                       want.pay_char, payload_char);
            if (frame_event !== want.event_code)
              $display("%0t: frame_event expected %0d actual %0d", $time,
                       want.event_code, frame_event);
          end
        end
      end
      if (in_valid && !in_stall) outcomes_due.push_back(decode_char(rx_char));
    end
    pending = outcomes_due.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives characters into the ASCII frame receiver: a directed run through the
// header, address, length and trailer corner cases, then random frames, some
// well formed and some broken, under three idle patterns and several station
// addresses. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import afr_pkg::*;

  localparam int ITEMS_PER_PHASE = 310;

  logic       clk;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = CFG_ADDR_HI;
  logic [7:0] cfg_data  = 8'h00;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_char   = 8'h00;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire        payload_valid;
  wire  [7:0] payload_char;
  wire  [1:0] frame_event;

  int chk_errors;
  int chk_pending;

  // idle rates in percent; changed per phase
  int send_idle_pct  = 38;
  int recv_stall_pct = 49;
  int chars_sent     = 0;

  // station address as last written, used to build matching frames
  logic [7:0] station_hi = ADDR_HI_RESET;
  logic [7:0] station_lo = ADDR_LO_RESET;
  logic [7:0] frame_bytes[$];

  ascii_frame_receiver_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_char      (rx_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_valid(payload_valid),
    .payload_char (payload_char),
    .frame_event  (frame_event)
  );

  afr_frame_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_char      (rx_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_valid(payload_valid),
    .payload_char (payload_char),
    .frame_event  (frame_event),
    .errors       (chk_errors),
    .pending      (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: stall at random, at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: far beyond the slowest legal run (a few thousand items with
  // long stalls on both sides)
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Offer one character; return at the edge where it is taken.
  // in_stall is sampled at the falling edge, where it holds the value that
  // the next rising edge will see.
  task automatic send_char(input logic [7:0] c);
    logic stalled;
    // idle a random number of cycles first, so gaps hit every frame position
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_char  <= c;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    chars_sent++;
  endtask

  // Hold the input idle until every expected result has come back
  task automatic wait_drain();
    logic empty;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      empty = (chk_pending == 0);
      @(posedge clk);
    end while (!empty);
    // leave a little margin
    repeat (3) @(posedge clk);
  endtask

  // Write both address registers back to back; only while idle
  task automatic set_station(input logic [7:0] hi, input logic [7:0] lo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ADDR_HI;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= CFG_ADDR_LO;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_we     <= 1'b0;
    station_hi = hi;
    station_lo = lo;
  endtask

  // Hex digit as a character, letters in random case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    if ($urandom_range(1)) return 8'h41 + 8'(v) - 8'd10;
    return 8'h61 + 8'(v) - 8'd10;
  endfunction

  // Build one well-formed frame for the current station address.
  // Most lengths are short; a few run to the largest payload of 510.
  task automatic build_frame();
    int         r;
    logic [7:0] len;
    frame_bytes.delete();
    r = $urandom_range(99);
    if (r < 2) len = 8'hFF;
    else if (r < 15) len = 8'($urandom_range(16, 63));
    else len = 8'($urandom_range(15));
    frame_bytes.push_back(CH_F);
    frame_bytes.push_back(CH_F);
    frame_bytes.push_back(station_hi);
    frame_bytes.push_back(station_lo);
    frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes.push_back(hex_char(len[7:4]));
    frame_bytes.push_back(hex_char(len[3:0]));
    repeat (2 * int'(len)) frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes.push_back(CH_8);
    frame_bytes.push_back(CH_0);
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) send_char(frame_bytes[i]);
  endtask

  // Random traffic: mostly good frames, some corrupted or cut short, and
  // short bursts of line noise. Drain once midway.
  task automatic run_traffic(input int quota);
    int stop_at;
    int half_way;
    int choice;
    int idx;
    bit drained;
    stop_at  = chars_sent + quota;
    half_way = chars_sent + quota / 2;
    drained  = 1'b0;
    while (chars_sent < stop_at) begin
      if (!drained && chars_sent >= half_way) begin
        wait_drain();
        drained = 1'b1;
      end
      choice = $urandom_range(99);
      if (choice < 10) begin
        // noise, with plenty of 'F' so false header starts happen
        repeat ($urandom_range(1, 5))
          send_char($urandom_range(2) == 0 ? CH_F : 8'($urandom_range(255)));
      end else begin
        build_frame();
        if (choice < 30) begin
          // corrupt one character, favoring header and length positions
          if ($urandom_range(1)) idx = $urandom_range(7);
          else idx = $urandom_range(frame_bytes.size() - 1);
          frame_bytes[idx] = 8'($urandom_range(255));
          // sometimes drop the rest of the frame
          if ($urandom_range(1))
            while (frame_bytes.size() > idx + 1) void'(frame_bytes.pop_back());
        end
        send_frame_bytes();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset address '0','1'
    // non-'F' while hunting
    send_char(8'hFF);
    // address mismatch on the second address character
    send_char(CH_F); send_char(CH_F); send_char(8'h30); send_char(8'h00);
    // zero length frame: straight to the trailer; skip characters at extremes
    send_char(CH_F); send_char(CH_F); send_char(8'h30); send_char(8'h31);
    send_char(8'h00); send_char(8'hFF); send_char(8'h30); send_char(8'h30);
    send_char(CH_8); send_char(CH_0);
    // non-hex high length digit
    send_char(CH_F); send_char(CH_F); send_char(8'h30); send_char(8'h31);
    send_char(8'h41); send_char(8'h42); send_char(8'h67);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drain();
      case (ph)
        0: begin
          send_idle_pct  = 38;
          recv_stall_pct = 49;
          set_station(8'h00, 8'hFF);
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 38;
          set_station(8'hFF, 8'h00);
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_station(CH_F, 8'($urandom_range(255)));
        end
      endcase
      run_traffic(ITEMS_PER_PHASE);
    end

    wait_drain();
    if (chk_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
